// ----- design/rga_pkg.sv -----
// ----------------------------------------------------------------------------
// rga_pkg: shared types and constants for range-gated association
// Field widths, item kind codes, the sequencer state type and the reset
// value of the gate register.
// ----------------------------------------------------------------------------
`default_nettype none

package rga_pkg;

    localparam int unsigned POS_W           = 24;
    localparam int unsigned RANGE_W         = 24;
    localparam int unsigned GATE_W          = 20;
    localparam int unsigned TAG_W           = 8;
    localparam int unsigned IDX_W           = 4;
    localparam int unsigned KIND_W          = 2;
    localparam int unsigned DEFAULT_ENTRIES = 16;

    // 100 m in sixteenths of a metre.
    localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(1600);

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_FINAL
    } t_state;

endpackage : rga_pkg

`default_nettype wire

// ----- design/range_gate_association.sv -----
// ----------------------------------------------------------------------------
// range_gate_association: range-gated association against a position table
// Holds up to ENTRIES x,y positions in two synchronous memories and, for each
// range query, reports every stored entry whose distance from the reference
// point lies within the measured range plus or minus the gate half-width.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  --------------------------------
//  in       input      i_in_valid / o_in_stall   kind, pos_x, pos_y, range, tag
//  out      output     o_out_valid / i_out_stall entry_index, echo_tag,
//                                                matched, last
//  cfg      input      i_cfg_valid / o_cfg_ready gate half-width (20 bits)
//
//  Clear and append items leave the block idle, so the input can take the
//  next item at once. A query stalls the input from its transfer until the
//  block is idle again: the set-up state squares the bounds, the walk reads
//  one entry a cycle from the memory port while the output register can
//  take a result, four stages (read data, difference, square, compare)
//  drain, the walk state sees the pipeline empty, the final state loads the
//  final result and the block then returns to idle. The whole walk freezes
//  while the output register holds an unaccepted result, so downstream
//  stalls lengthen a query.
//  Reset is synchronous and active low: it empties the table, restores the
//  gate to 100 m and discards any query in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module range_gate_association #(
    parameter int unsigned ENTRIES = rga_pkg::DEFAULT_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rga_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [rga_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [rga_pkg::POS_W-1:0]    i_pos_y,
    input  logic [rga_pkg::RANGE_W-1:0]         i_measured_range,
    input  logic [rga_pkg::TAG_W-1:0]           i_meas_tag,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rga_pkg::IDX_W-1:0]           o_entry_index,
    output logic [rga_pkg::TAG_W-1:0]           o_echo_tag,
    output logic                                o_matched,
    output logic                                o_last,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rga_pkg::GATE_W-1:0]          i_cfg_data
);

    import rga_pkg::*;

    // Index width addresses the memories; count width can also hold ENTRIES.
    localparam int unsigned IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW    = $clog2(ENTRIES + 1);
    localparam int unsigned MAG_W = POS_W + 1;        // |difference| fits here
    localparam int unsigned SQ_W  = 2 * MAG_W;        // one squared term
    localparam int unsigned D2_W  = SQ_W + 1;         // sum of two squares
    localparam int unsigned HI_W  = RANGE_W + 1;      // range + gate
    localparam int unsigned LO2_W = 2 * RANGE_W;
    localparam int unsigned HI2_W = 2 * HI_W;

    // ------------------------------------------------------------------
    // Position memories. Appends write only while idle and the walk issues
    // reads only while the input side is stalled, so no write coincides
    // with a read that the walk uses and no forwarding is needed.
    // ------------------------------------------------------------------
    logic [POS_W-1:0] r_tab_x [ENTRIES];
    logic [POS_W-1:0] r_tab_y [ENTRIES];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count;
    logic [GATE_W-1:0] r_gate;

    // Query context captured on the input transfer; the squared bounds follow in set-up.
    logic [POS_W-1:0]   r_ref_x, r_ref_y;
    logic [TAG_W-1:0]   r_tag;
    logic [RANGE_W-1:0] r_lo;
    logic [HI_W-1:0]    r_hi;
    logic [LO2_W-1:0]   r_lo2;
    logic [HI2_W-1:0]   r_hi2;

    // Walk pipeline.
    logic [CW-1:0]    r_rd_idx;
    logic             r_v1, r_v2, r_v3, r_v4;
    logic [IW-1:0]    r_idx1, r_idx2, r_idx3, r_idx4;
    logic [POS_W-1:0] r_m1_x, r_m1_y;
    logic [MAG_W-1:0] r_ax, r_ay;
    logic [SQ_W-1:0]  r_sq_x, r_sq_y;

    // The most recent match is held back one step so that the final one
    // can be marked as last.
    logic          r_pend_v;
    logic [IW-1:0] r_pend_idx;

    // Output register.
    logic             r_out_valid;
    logic [IW-1:0]    r_out_idx;
    logic [TAG_W-1:0] r_out_tag;
    logic             r_out_matched;
    logic             r_out_last;

    logic w_in_xfer, w_out_free, w_adv, w_more, w_busy;
    logic w_issue, w_push, w_fin_load, w_in_gate;
    logic w_wr_en;
    logic signed [MAG_W-1:0] w_dx, w_dy;
    logic [D2_W-1:0]         w_d2;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    // The walk moves only when the output register can take a result.
    assign w_adv      = w_out_free;
    assign w_more     = (r_rd_idx < r_count);
    assign w_busy     = r_v1 || r_v2 || r_v3 || r_v4;
    assign w_wr_en    = w_in_xfer && (i_kind == KIND_APPEND) && (r_count < CW'(ENTRIES));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_issue    = 1'b0;
        w_push     = 1'b0;
        w_fin_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (i_kind == KIND_QUERY)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                w_issue = w_more && w_adv;
                w_push  = w_adv && r_v4 && r_pend_v;
                if (!w_more && !w_busy) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                w_fin_load = w_out_free;
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration, table count and memory writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= GATE_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gate <= i_cfg_data;
            end
            if (w_in_xfer) begin
                unique case (i_kind)
                    KIND_CLEAR:  r_count <= '0;
                    KIND_APPEND: begin
                        if (w_wr_en) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_tab_x[r_count[IW-1:0]] <= i_pos_x;
            r_tab_y[r_count[IW-1:0]] <= i_pos_y;
        end
    end

    // Registered read port; the data register holds while the walk is frozen.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_x <= r_tab_x[r_rd_idx[IW-1:0]];
            r_m1_y <= r_tab_y[r_rd_idx[IW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Query set-up: bounds on the transfer, their squares in the set-up state that follows.
    // A range below the gate clamps the lower bound to zero.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && (i_kind == KIND_QUERY)) begin
            r_ref_x <= i_pos_x;
            r_ref_y <= i_pos_y;
            r_tag   <= i_meas_tag;
            r_lo    <= (i_measured_range > RANGE_W'(r_gate))
                       ? i_measured_range - RANGE_W'(r_gate) : '0;
            r_hi    <= HI_W'(i_measured_range) + HI_W'(r_gate);
        end
        if (r_state == ST_SETUP) begin
            r_lo2 <= LO2_W'(r_lo) * LO2_W'(r_lo);
            r_hi2 <= HI2_W'(r_hi) * HI2_W'(r_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (r_state == ST_SETUP) begin
            r_rd_idx <= '0;
        end else if (w_issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Walk pipeline: difference and magnitude, squares, sum and gate test.
    // Differences of two 24-bit signed values need 25 bits; the magnitude
    // of the most negative one still fits as an unsigned 25-bit value.
    // ------------------------------------------------------------------
    assign w_dx = $signed({r_m1_x[POS_W-1], r_m1_x}) - $signed({r_ref_x[POS_W-1], r_ref_x});
    assign w_dy = $signed({r_m1_y[POS_W-1], r_m1_y}) - $signed({r_ref_y[POS_W-1], r_ref_y});

    assign w_d2      = D2_W'(r_sq_x) + D2_W'(r_sq_y);
    assign w_in_gate = (w_d2 >= D2_W'(r_lo2)) && (w_d2 <= D2_W'(r_hi2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3 && w_in_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_idx1 <= r_rd_idx[IW-1:0];
            r_idx2 <= r_idx1;
            r_idx3 <= r_idx2;
            r_idx4 <= r_idx3;
            r_ax   <= w_dx[MAG_W-1] ? MAG_W'(-w_dx) : MAG_W'(w_dx);
            r_ay   <= w_dy[MAG_W-1] ? MAG_W'(-w_dy) : MAG_W'(w_dy);
            r_sq_x <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_sq_y <= SQ_W'(r_ay) * SQ_W'(r_ay);
        end
    end

    // ------------------------------------------------------------------
    // Held-back match and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (r_state == ST_SETUP) begin
            r_pend_v <= 1'b0;
        end else if ((r_state == ST_WALK) && w_adv && r_v4) begin
            r_pend_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WALK) && w_adv && r_v4) begin
            r_pend_idx <= r_idx4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push || w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_idx     <= r_pend_idx;
            r_out_tag     <= r_tag;
            r_out_matched <= 1'b1;
            r_out_last    <= 1'b0;
        end else if (w_fin_load) begin
            // Either the held-back match closes the query, or no entry
            // matched and the no-match marker is sent instead.
            r_out_idx     <= r_pend_v ? r_pend_idx : '0;
            r_out_tag     <= r_tag;
            r_out_matched <= r_pend_v;
            r_out_last    <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_index = IDX_W'(r_out_idx);
    assign o_echo_tag    = r_out_tag;
    assign o_matched     = r_out_matched;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("table count exceeds the number of entries");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(r_v1 || r_v2 || r_v3 || r_v4))
        else $error("walk pipeline not empty while idle");

    a_nonlast_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_matched)
        else $error("non-final result without a match");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_count))
        else $error("table count changed during a query");
`endif

endmodule : range_gate_association

`default_nettype wire
